/* hw/rtl/midi_channel_message_parser_assert.svh */
// assertion macros for the midi channel message parser checker
// no dependencies, included by the checker file
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_ASSERT_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_ASSERT_SVH

// checked only out of reset
`define MCMP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MCMP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mcmp_pkg.sv */
// types and constants shared by the midi channel message parser
// no dependencies
package mcmp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DATA_W = 7;

  localparam logic [7:0] RT_MIN  = 8'hF8;
  localparam logic [7:0] SYS_MIN = 8'hF0;

  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_CH_AT    = 4'hD;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef enum logic [1:0] {
    KIND_ON    = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  // packed so that kind sits in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0] data2;
    logic [DATA_W-1:0] data1;
    logic [4:0]        channel;
    logic [2:0]        message_type;
    kind_t             kind;
  } msg_t;

  localparam int unsigned TUSER_W = 5;
  localparam int unsigned TDATA_W = 24;

endpackage

/* hw/rtl/midi_channel_message_parser.sv */
// midi channel message parser with running status, top level
// uses mcmp_pkg, mcmp_in_stage, mcmp_parser, mcmp_out_stage
//
//  channel | dir | width     | contents
//  in_     | in  | 8         | rx_byte
//  out_    | out | 24 data   | data: channel, data1, data2
//          |     | 5 user    | user: kind, message_type
//  cfg_    | in  | 1         | zero_velocity_is_off
//
// one byte a cycle sustained unless out_tready stalls, via byte register then result register
// the byte register feeds the parser state update and the result register
// in_tready drops only when both registers hold beats and out_tready is low
// synchronous active-low reset clears parser state and the config bit
module midi_channel_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [4:0]  out_tuser,   // kind, message_type
  output logic [23:0] out_tdata,   // channel, data1, data2
  input  logic        cfg_we,
  input  logic        cfg_wdata    // zero_velocity_is_off
);

  logic           zvo_r;
  logic           ds_ready;
  logic           byte_vld;
  logic [7:0]     byte_q;
  logic           step;
  logic           emit;
  mcmp_pkg::msg_t msg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zvo_r <= 1'b0;
    end else if (cfg_we) begin
      zvo_r <= cfg_wdata;
    end
  end

  assign step = byte_vld && ds_ready;

  mcmp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ds_ready  (ds_ready),
    .byte_vld  (byte_vld),
    .byte_q    (byte_q)
  );

  mcmp_parser u_parser (
    .clk                  (clk),
    .rst_n                (rst_n),
    .step                 (step),
    .rx_byte              (byte_q),
    .zero_velocity_is_off (zvo_r),
    .emit                 (emit),
    .msg                  (msg)
  );

  mcmp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && emit),
    .msg        (msg),
    .ready      (ds_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

/* hw/rtl/mcmp_in_stage.sv */
// input register for received midi bytes
// uses mcmp_pkg
module mcmp_in_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mcmp_pkg::BYTE_W-1:0]  in_tdata,
  input  logic                         ds_ready,
  output logic                         byte_vld,
  output logic [mcmp_pkg::BYTE_W-1:0]  byte_q
);

  logic                        vld_r;
  logic [mcmp_pkg::BYTE_W-1:0] byte_r;

  assign in_tready = !vld_r || ds_ready;
  assign byte_vld  = vld_r;
  assign byte_q    = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

/* hw/rtl/mcmp_parser.sv */
// running status parser state and message assembly
// uses mcmp_pkg
module mcmp_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [mcmp_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        zero_velocity_is_off,
  output logic                        emit,
  output mcmp_pkg::msg_t              msg
);

  logic [7:0]                  status_r, status_nxt;
  logic [1:0]                  expected_r, expected_nxt;
  logic                        index_r, index_nxt;
  logic [mcmp_pkg::DATA_W-1:0] first_r, first_nxt;
  logic [mcmp_pkg::DATA_W-1:0] d1, d2;
  logic [3:0]                  hi;

  assign hi = status_r[7:4];

  always_comb begin
    status_nxt   = status_r;
    expected_nxt = expected_r;
    index_nxt    = index_r;
    first_nxt    = first_r;
    emit         = 1'b0;
    d1           = rx_byte[mcmp_pkg::DATA_W-1:0];
    d2           = '0;
    if (step) begin
      priority if (rx_byte >= mcmp_pkg::RT_MIN) begin
        // realtime, state untouched
      end else if (rx_byte >= mcmp_pkg::SYS_MIN) begin
        status_nxt   = '0;
        expected_nxt = mcmp_pkg::CNT_NONE;
        index_nxt    = 1'b0;
      end else if (rx_byte[7]) begin
        status_nxt   = rx_byte;
        index_nxt    = 1'b0;
        if (rx_byte[7:4] == mcmp_pkg::HI_PROG || rx_byte[7:4] == mcmp_pkg::HI_CH_AT) begin
          expected_nxt = mcmp_pkg::CNT_ONE;
        end else begin
          expected_nxt = mcmp_pkg::CNT_TWO;
        end
      end else if (expected_r == mcmp_pkg::CNT_ONE) begin
        index_nxt = 1'b0;
        emit      = 1'b1;
      end else if (expected_r == mcmp_pkg::CNT_TWO) begin
        if (!index_r) begin
          first_nxt = rx_byte[mcmp_pkg::DATA_W-1:0];
          index_nxt = 1'b1;
        end else begin
          index_nxt = 1'b0;
          emit      = 1'b1;
          d1        = first_r;
          d2        = rx_byte[mcmp_pkg::DATA_W-1:0];
        end
      end
    end
  end

  always_comb begin
    msg.data1        = d1;
    msg.data2        = d2;
    msg.message_type = hi[2:0];
    msg.channel      = {1'b0, status_r[3:0]} + 5'd1;
    if (hi == mcmp_pkg::HI_NOTE_ON) begin
      msg.kind = (d2 == '0 && zero_velocity_is_off) ? mcmp_pkg::KIND_OFF : mcmp_pkg::KIND_ON;
    end else if (hi == mcmp_pkg::HI_NOTE_OFF) begin
      msg.kind = mcmp_pkg::KIND_OFF;
    end else begin
      msg.kind = mcmp_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= '0;
      expected_r <= mcmp_pkg::CNT_NONE;
      index_r    <= 1'b0;
      first_r    <= '0;
    end else begin
      status_r   <= status_nxt;
      expected_r <= expected_nxt;
      index_r    <= index_nxt;
      first_r    <= first_nxt;
    end
  end

endmodule

/* hw/rtl/mcmp_out_stage.sv */
// result register for finished channel messages
// uses mcmp_pkg
module mcmp_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  mcmp_pkg::msg_t                msg,
  output logic                          ready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mcmp_pkg::TUSER_W-1:0]  out_tuser,
  output logic [mcmp_pkg::TDATA_W-1:0]  out_tdata
);

  logic           vld_r;
  mcmp_pkg::msg_t msg_r;

  assign ready      = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tuser  = {msg_r.message_type, msg_r.kind};
  assign out_tdata  = {5'd0, msg_r.data2, msg_r.data1, msg_r.channel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      msg_r <= msg;
    end
  end

endmodule

/* hw/rtl/mcmp_checker.sv */
// port-level checks for the midi channel message parser, bound to the top
// uses mcmp_pkg and midi_channel_message_parser_assert.svh
`include "midi_channel_message_parser_assert.svh"

module mcmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [4:0]  out_tuser,
  input logic [23:0] out_tdata
);

  logic        stall;
  logic        on_beat;
  logic [28:0] out_beat;

  assign stall    = out_tvalid && !out_tready;
  assign on_beat  = out_tvalid && out_tuser[1:0] == mcmp_pkg::KIND_ON;
  assign out_beat = {out_tuser, out_tdata};

  `MCMP_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid, "result beat right after reset")

  `MCMP_ASSERT(a_out_hold, clk, rst_n, stall |=> out_tvalid && $stable(out_beat), "stalled beat changed")

  `MCMP_ASSERT(a_in_free, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty result register")

  `MCMP_ASSERT(a_kind_type, clk, rst_n, on_beat |-> out_tuser[4:2] == 3'd1 && out_tdata[4:0] != 5'd0, "bad note on beat")

endmodule

bind midi_channel_message_parser mcmp_checker u_mcmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
